### hw/rtl/acs_pkg.sv
// Shared types and constants for the ADC offset calibration and current scaling block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package acs_pkg;

   localparam int SAMPLE_BITS   = 16;      // significant bits of an ADC code
   localparam int SAMPLE_W      = 16;      // width of a sample field
   localparam int SUM_W         = 28;      // calibration sum width
   localparam int COUNT_W       = 12;      // sample_count / frame index width
   localparam int CUR_W         = 28;      // phase U/V current width
   localparam int CUR_W_W       = 29;      // phase W current width
   localparam int GAIN_W        = 12;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS     = SUM_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 120;

   localparam logic [COUNT_W-1:0]       COUNT_RESET  = COUNT_W'(1000);
   // 10/65536 V per code, 200 A/V, Q16 output: exactly 2000 per code
   localparam logic signed [GAIN_W-1:0] CURRENT_GAIN = GAIN_W'(2000);

   typedef enum logic {
      CMD_MEASURE = 1'b0,
      CMD_DIVIDE  = 1'b1
   } cmd_kind_type;

   typedef enum logic {
      MODE_CALIB   = 1'b0,
      MODE_MEASURE = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_MEASURE = 1'b0,
      KIND_CALIB   = 1'b1
   } rsp_kind_type;

   // measure: a/b hold the samples; divide: a/b hold the sums, frames the divisor
   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [SUM_W-1:0]    a;
      logic signed [SUM_W-1:0]    b;
      logic [COUNT_W-1:0]         frames;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic signed [SUM_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_BITS-1:0] s;
      s = SAMPLE_BITS'(raw);
      return SUM_W'(s);
   endfunction

endpackage

### hw/rtl/acs_front.sv
// Front end: accepts ADC frames, accumulates calibration sums and issues commands.
// Depends on acs_pkg; feeds acs_queue.
`timescale 1ns / 1ps

module acs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   input  logic [acs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          csr_wr_en,
   input  logic [acs_pkg::COUNT_W-1:0]   csr_wr_data,
   input  acs_pkg::queue_status_type     q_status,
   output logic                          push,
   output acs_pkg::cmd_type              push_cmd
);
   import acs_pkg::*;

   logic [COUNT_W-1:0]      sample_count_ff;
   logic signed [SUM_W-1:0] sum_u_ff, sum_u_in;
   logic signed [SUM_W-1:0] sum_v_ff, sum_v_in;
   logic [COUNT_W-1:0]      frame_index_ff, frame_index_in;
   logic signed [SUM_W-1:0] s_u, s_v, acc_u, acc_v;
   logic [COUNT_W:0]        frames;
   logic                    accept;
   logic                    finish;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   assign s_u    = sext_sample(req_tdata[SAMPLE_W-1:0]);
   assign s_v    = sext_sample(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
   assign acc_u  = sum_u_ff + s_u;
   assign acc_v  = sum_v_ff + s_v;
   assign frames = {1'b0, frame_index_ff} + (COUNT_W+1)'(1);
   // a zero count acts as one: every calibration frame finishes
   assign finish = frames >= {1'b0, sample_count_ff};

   always_comb begin
      sum_u_in       = sum_u_ff;
      sum_v_in       = sum_v_ff;
      frame_index_in = frame_index_ff;
      push           = 1'b0;
      push_cmd.kind  = CMD_MEASURE;
      push_cmd.a     = s_u;
      push_cmd.b     = s_v;
      push_cmd.frames = frames[COUNT_W-1:0];
      if (accept) begin
         if (mode_type'(req_tuser) == MODE_CALIB) begin
            if (finish) begin
               push           = 1'b1;
               push_cmd.kind  = CMD_DIVIDE;
               push_cmd.a     = acc_u;
               push_cmd.b     = acc_v;
               sum_u_in       = '0;
               sum_v_in       = '0;
               frame_index_in = '0;
            end else begin
               sum_u_in       = acc_u;
               sum_v_in       = acc_v;
               frame_index_in = frames[COUNT_W-1:0];
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= COUNT_RESET;
         sum_u_ff        <= '0;
         sum_v_ff        <= '0;
         frame_index_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            sample_count_ff <= csr_wr_data;
         end
         sum_u_ff       <= sum_u_in;
         sum_v_ff       <= sum_v_in;
         frame_index_ff <= frame_index_in;
      end
   end

endmodule

### hw/rtl/acs_queue.sv
// Short command queue between front end and back end; depends on acs_pkg.
// First-word fall-through; per cycle, a push unless full, a pop unless empty.
`timescale 1ns / 1ps

module acs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  acs_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output acs_pkg::cmd_type          pop_cmd,
   output acs_pkg::queue_status_type status
);
   import acs_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/acs_divider.sv
// Two-lane restoring divider: signed calibration sums by the unsigned frame count,
// one quotient bit per cycle, truncated toward zero. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [acs_pkg::SUM_W-1:0]   dividend_u,
   input  logic signed [acs_pkg::SUM_W-1:0]   dividend_v,
   input  logic [acs_pkg::COUNT_W-1:0]        divisor,
   output logic                               done,
   output logic signed [acs_pkg::SAMPLE_W-1:0] quot_u,
   output logic signed [acs_pkg::SAMPLE_W-1:0] quot_v
);
   import acs_pkg::*;

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIV_CNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]     divisor_ff;
   logic                   neg_u_ff, neg_v_ff;
   logic [SUM_W-1:0]       q_u_ff, q_v_ff, q_u_in, q_v_in;
   logic [COUNT_W-1:0]     rem_u_ff, rem_v_ff, rem_u_in, rem_v_in;
   logic [SUM_W-1:0]       quot_u_full, quot_v_full;

   // shift the next dividend bit into the remainder, subtract where it fits
   function automatic logic [COUNT_W+SUM_W-1:0] div_step(
      input logic [COUNT_W-1:0] rem,
      input logic [SUM_W-1:0]   q,
      input logic [COUNT_W-1:0] dvs
   );
      logic [COUNT_W:0] trial;
      logic [COUNT_W:0] diff;
      logic             fits;
      trial = {rem, q[SUM_W-1]};
      diff  = trial - {1'b0, dvs};
      fits  = trial >= {1'b0, dvs};
      return {fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0], q[SUM_W-2:0], fits};
   endfunction

   assign {rem_u_in, q_u_in} = div_step(rem_u_ff, q_u_ff, divisor_ff);
   assign {rem_v_in, q_v_in} = div_step(rem_v_ff, q_v_ff, divisor_ff);

   assign quot_u_full = neg_u_ff ? -q_u_ff : q_u_ff;
   assign quot_v_full = neg_v_ff ? -q_v_ff : q_v_ff;
   assign quot_u      = quot_u_full[SAMPLE_W-1:0];
   assign quot_v      = quot_v_full[SAMPLE_W-1:0];
   assign done        = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(DIV_STEPS-1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         neg_u_ff   <= dividend_u[SUM_W-1];
         neg_v_ff   <= dividend_v[SUM_W-1];
         q_u_ff     <= dividend_u[SUM_W-1] ? -dividend_u : dividend_u;
         q_v_ff     <= dividend_v[SUM_W-1] ? -dividend_v : dividend_v;
         rem_u_ff   <= '0;
         rem_v_ff   <= '0;
      end else if (busy_ff) begin
         q_u_ff   <= q_u_in;
         q_v_ff   <= q_v_in;
         rem_u_ff <= rem_u_in;
         rem_v_ff <= rem_v_in;
      end
   end

endmodule

### hw/rtl/acs_back.sv
// Back end: executes queued commands, holds the offsets and the result register.
// Depends on acs_pkg and acs_divider.
`timescale 1ns / 1ps

module acs_back (
   input  logic                           clock,
   input  logic                           reset,
   input  acs_pkg::queue_status_type      q_status,
   input  acs_pkg::cmd_type               pop_cmd,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_tuser,
   output logic [acs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import acs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_HOLD  = 4'b1000
   } back_state_type;

   back_state_type               state_ff, state_in;
   logic signed [SAMPLE_W-1:0]   offset_u_ff, offset_v_ff;
   logic signed [CUR_W-1:0]      cur_u_ff, cur_v_ff;
   rsp_kind_type                 kind_ff;
   logic signed [SAMPLE_W:0]     diff_u, diff_v;
   logic signed [CUR_W:0]        mul_u, mul_v;
   logic signed [CUR_W_W-1:0]    cur_w;
   logic                         div_start, div_done;
   logic signed [SAMPLE_W-1:0]   quot_u, quot_v;
   logic                         out_free;
   logic                         rsp_valid_ff;
   logic                         rsp_user_ff;
   logic [RSP_DATA_W-1:0]        rsp_data_ff;

   acs_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_u (pop_cmd.a),
      .dividend_v (pop_cmd.b),
      .divisor    (pop_cmd.frames),
      .done       (div_done),
      .quot_u     (quot_u),
      .quot_v     (quot_v)
   );

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign div_start = pop && (pop_cmd.kind == CMD_DIVIDE);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign diff_u = $signed(pop_cmd.a[SAMPLE_W:0]) - {offset_u_ff[SAMPLE_W-1], offset_u_ff};
   assign diff_v = $signed(pop_cmd.b[SAMPLE_W:0]) - {offset_v_ff[SAMPLE_W-1], offset_v_ff};
   assign mul_u  = diff_u * CURRENT_GAIN;
   assign mul_v  = diff_v * CURRENT_GAIN;
   assign cur_w  = -CUR_W_W'(cur_u_ff) - CUR_W_W'(cur_v_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = (pop_cmd.kind == CMD_DIVIDE) ? ST_DIV : ST_WRITE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_u_ff  <= '0;
         offset_v_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DIV && div_done) begin
            offset_u_ff <= quot_u;
            offset_v_ff <= quot_v;
         end
         if (state_ff == ST_WRITE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_u_ff <= (pop_cmd.kind == CMD_DIVIDE) ? '0 : mul_u[CUR_W-1:0];
         cur_v_ff <= (pop_cmd.kind == CMD_DIVIDE) ? '0 : mul_v[CUR_W-1:0];
         kind_ff  <= (pop_cmd.kind == CMD_DIVIDE) ? KIND_CALIB : KIND_MEASURE;
      end
      if (state_ff == ST_WRITE && out_free) begin
         rsp_user_ff <= kind_ff;
         rsp_data_ff <= {3'b000, offset_v_ff, offset_u_ff, cur_w, cur_v_ff, cur_u_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/adc_offset_calib_current_scale_unit.sv
// Top level of the ADC offset calibration and current scaling block.
// Measurement frame: queued, then popped by the back end in idle and registered in write;
// final calibration frame: also passes the divide and hold states, paced by the 28-step
// one-bit-per-cycle divider in the back end. Front end takes a frame per cycle while the
// 2-entry command queue has room; the back end pops a command only when back in idle.
// Synchronous active-high reset clears sums, frame index, offsets, queue and result valid;
// sample_count returns to 1000.
`timescale 1ns / 1ps

module adc_offset_calib_current_scale_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_tuser,   // mode
   input  logic [acs_pkg::REQ_DATA_W-1:0] req_tdata,   // sample_u, sample_v
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_tuser,   // kind
   // current_u, current_v, current_w, offset_u_out, offset_v_out, 3 zero bits
   output logic [acs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [acs_pkg::COUNT_W-1:0]    csr_wr_data
);
   import acs_pkg::*;

   queue_status_type q_status;
   logic             push, pop;
   cmd_type          push_cmd, pop_cmd;

   acs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   acs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   acs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // calibration results carry no currents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[84:0] == '0)
      else $error("calibration result with nonzero currents");

   // W must be minus U minus V on every measurement result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         $signed(rsp_tdata[84:56]) ==
         -$signed({rsp_tdata[27], rsp_tdata[27:0]}) - $signed({rsp_tdata[55], rsp_tdata[55:28]}))
      else $error("current_w mismatch");

   // the queue fills only through an accepted request
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("ready dropped without a request");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
